@@ src/fpha_pkg.sv @@
// Shared constants, codes and types for the fit policy hole allocator.
package fpha_pkg;

    localparam int DEF_HOLES     = 16;
    localparam int DEF_SIZE_BITS = 16;

    localparam int FUNC_BITS   = 1;
    localparam int SLOT_BITS   = 4;
    localparam int AMOUNT_BITS = 16;
    localparam int BLOCK_BITS  = 4;
    localparam int LEFT_BITS   = 16;

    localparam int POLICY_BITS  = 2;
    localparam int COUNT_BITS   = 5;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DAT_BITS = 5;

    localparam logic [FUNC_BITS-1:0] FUNC_LOAD  = 1'b0;
    localparam logic [FUNC_BITS-1:0] FUNC_ALLOC = 1'b1;

    localparam logic [POLICY_BITS-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_BITS-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_BITS-1:0] POLICY_WORST = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_POLICY = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT  = 1'b1;

    typedef struct packed {
        logic clear;
        logic step;
    } pick_ctl_t;

endpackage

@@ src/fpha_req_if.sv @@
// Request channel: load or allocate items.
interface fpha_req_if;
    import fpha_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FUNC_BITS-1:0]   func;
    logic [SLOT_BITS-1:0]   slot;
    logic [AMOUNT_BITS-1:0] amount;

    modport source (output valid, func, slot, amount, input ready);
    modport sink   (input valid, func, slot, amount, output ready);
endinterface

@@ src/fpha_rsp_if.sv @@
// Response channel: allocation results.
interface fpha_rsp_if;
    import fpha_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  granted;
    logic [BLOCK_BITS-1:0] block;
    logic [LEFT_BITS-1:0]  left_over;

    modport source (output valid, granted, block, left_over, input ready);
    modport sink   (input valid, granted, block, left_over, output ready);
endinterface

@@ src/fpha_cfg_if.sv @@
// Configuration write channel.
interface fpha_cfg_if;
    import fpha_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [CFG_DAT_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/fpha_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fpha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ src/fpha_pick.sv @@
// Shared compare unit that keeps the running choice of hole during a scan.
module fpha_pick #(
    parameter int SIZE_BITS = fpha_pkg::DEF_SIZE_BITS,
    parameter int IDX_W     = 9
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fpha_pkg::pick_ctl_t                ctl,
    input  logic [fpha_pkg::POLICY_BITS-1:0]   policy,
    input  logic [SIZE_BITS-1:0]               want,
    input  logic [SIZE_BITS-1:0]               cand_size,
    input  logic [IDX_W-1:0]                   cand_idx,
    output logic                               granted,
    output logic [IDX_W-1:0]                   at,
    output logic [SIZE_BITS-1:0]               size
);
    import fpha_pkg::*;

    logic                 have_reg, have_next;
    logic [IDX_W-1:0]     at_reg, at_next;
    logic [SIZE_BITS-1:0] best_reg, best_next;
    logic                 fits;
    logic                 take;

    assign fits = (cand_size >= want);

    always_comb
    begin
        case (policy)
            POLICY_FIRST: take = fits && !have_reg;
            POLICY_BEST:  take = fits && (!have_reg || (cand_size <= best_reg));
            default:      take = !have_reg || (cand_size > best_reg);
        endcase
    end

    always_comb
    begin
        have_next = have_reg;
        at_next   = at_reg;
        best_next = best_reg;
        if (ctl.clear)
        begin
            have_next = 1'b0;
        end
        else if (ctl.step && take)
        begin
            have_next = 1'b1;
            at_next   = cand_idx;
            best_next = cand_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        at_reg   <= at_next;
        best_reg <= best_next;
    end

    always_comb
    begin
        case (policy)
            POLICY_FIRST: granted = have_reg;
            POLICY_BEST:  granted = have_reg;
            default:      granted = have_reg && (best_reg >= want);
        endcase
    end

    assign at   = at_reg;
    assign size = best_reg;
endmodule

@@ src/fit_policy_hole_allocator_unit.sv @@
// Fit policy hole allocator: top level with sequencer, hole table and config.
//
//  channel | dir | transfer when        | payload
//  cfg     | in  | cfg.valid&cfg.ready  | index, data
//  req     | in  | req.valid&req.ready  | func, slot, amount
//  rsp     | out | rsp.valid&rsp.ready  | granted, block, left_over
//
//  A load completes in the idle state. An allocate scans n = min(hole_count, HOLES) holes,
//  or goes straight to the done step when no holes are in use: the scan reads one hole per
//  cycle through the single RAM read port.
//  Reset sets the config registers to policy first fit, hole_count 0; the hole table is not cleared.
//  The result waits in an output register; req stays ready during that wait, and a
//  finished allocate holds in its last step until the output register frees.
module fit_policy_hole_allocator_unit #(
    parameter int HOLES     = fpha_pkg::DEF_HOLES,
    parameter int SIZE_BITS = fpha_pkg::DEF_SIZE_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    fpha_cfg_if.sink  cfg,
    fpha_req_if.sink  req,
    fpha_rsp_if.source rsp
);
    import fpha_pkg::*;

    localparam int IDX_W = ($clog2(HOLES + 1) > COUNT_BITS) ? $clog2(HOLES + 1) : COUNT_BITS;
    localparam int AW    = (HOLES > 1) ? $clog2(HOLES) : 1;
    localparam logic [IDX_W-1:0] HOLES_IDX = IDX_W'(HOLES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [POLICY_BITS-1:0] policy_reg;
    logic [COUNT_BITS-1:0]  count_reg;

    logic [1:0]           state_reg, state_next;
    logic [SIZE_BITS-1:0] want_reg, want_next;
    logic [IDX_W-1:0]     n_reg, n_next;
    logic [IDX_W-1:0]     iss_reg, iss_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 vld_reg, vld_next;

    logic                 rsp_valid_reg, rsp_valid_next;
    logic                 granted_reg, granted_next;
    logic [BLOCK_BITS-1:0] block_reg, block_next;
    logic [LEFT_BITS-1:0] left_reg, left_next;

    logic                 req_fire;
    logic                 done_go;
    logic [IDX_W-1:0]     count_ext;
    logic [IDX_W-1:0]     n_eff;
    logic [IDX_W-1:0]     slot_ext;
    logic [SIZE_BITS+AMOUNT_BITS-1:0] amt_wide;
    logic [SIZE_BITS-1:0] amt_size;
    logic [SIZE_BITS-1:0] remain;
    logic [SIZE_BITS+LEFT_BITS-1:0] rem_wide;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic [SIZE_BITS-1:0] ram_rdata;

    pick_ctl_t            pick_ctl;
    logic                 pick_granted;
    logic [IDX_W-1:0]     pick_at;
    logic [SIZE_BITS-1:0] pick_size;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_FIRST;
            count_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_POLICY: policy_reg <= cfg.data[POLICY_BITS-1:0];
                CFG_COUNT:  count_reg  <= cfg.data[COUNT_BITS-1:0];
                default:    ;
            endcase
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign done_go   = !rsp_valid_reg || rsp.ready;

    assign count_ext = IDX_W'(count_reg);
    assign n_eff     = (count_ext > HOLES_IDX) ? HOLES_IDX : count_ext;
    assign slot_ext  = {{(IDX_W-SLOT_BITS){1'b0}}, req.slot};
    assign amt_wide  = {{SIZE_BITS{1'b0}}, req.amount};
    assign amt_size  = amt_wide[SIZE_BITS-1:0];
    assign remain    = pick_size - want_reg;
    assign rem_wide  = {{LEFT_BITS{1'b0}}, remain};

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = slot_ext[AW-1:0];
        ram_wdata = amt_size;
        if (state_reg == S_DONE)
        begin
            ram_we    = done_go && pick_granted;
            ram_waddr = pick_at[AW-1:0];
            ram_wdata = remain;
        end
        else if (req_fire && (req.func == FUNC_LOAD) && (slot_ext < HOLES_IDX))
        begin
            ram_we = 1'b1;
        end
    end

    fpha_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (HOLES),
        .AW    (AW)
    ) u_holes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (iss_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign pick_ctl.clear = req_fire;
    assign pick_ctl.step  = vld_reg;

    fpha_pick #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W)
    ) u_pick (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (pick_ctl),
        .policy    (policy_reg),
        .want      (want_reg),
        .cand_size (ram_rdata),
        .cand_idx  (cmp_idx_reg),
        .granted   (pick_granted),
        .at        (pick_at),
        .size      (pick_size)
    );

    always_comb
    begin
        state_next     = state_reg;
        want_next      = want_reg;
        n_next         = n_reg;
        iss_next       = iss_reg;
        cmp_idx_next   = cmp_idx_reg;
        vld_next       = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        granted_next   = granted_reg;
        block_next     = block_reg;
        left_next      = left_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req.func == FUNC_ALLOC))
                begin
                    want_next  = amt_size;
                    n_next     = n_eff;
                    iss_next   = '0;
                    state_next = (n_eff == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (iss_reg < n_reg)
                begin
                    vld_next     = 1'b1;
                    cmp_idx_next = iss_reg;
                    iss_next     = iss_reg + 1'b1;
                end
                if (vld_reg && (cmp_idx_reg == (n_reg - 1'b1)))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (done_go)
                begin
                    rsp_valid_next = 1'b1;
                    granted_next   = pick_granted;
                    block_next     = pick_granted ? pick_at[BLOCK_BITS-1:0] : '0;
                    left_next      = pick_granted ? rem_wide[LEFT_BITS-1:0] : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vld_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            iss_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            vld_reg       <= vld_next;
            rsp_valid_reg <= rsp_valid_next;
            iss_reg       <= iss_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg    <= want_next;
        n_reg       <= n_next;
        cmp_idx_reg <= cmp_idx_next;
        granted_reg <= granted_next;
        block_reg   <= block_next;
        left_reg    <= left_next;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.granted   = granted_reg;
    assign rsp.block     = block_reg;
    assign rsp.left_over = left_reg;

`ifndef SYNTHESIS
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (iss_reg <= n_reg))
        else $error("scan issued past the holes in use");

    a_cmp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> ((state_reg == S_SCAN) && (cmp_idx_reg < n_reg)))
        else $error("compare outside the scan range");

    a_pick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && pick_granted) |-> (pick_at < n_reg))
        else $error("chosen hole outside the holes in use");

    a_alloc_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.func == FUNC_ALLOC) && (n_eff != '0)) |=> (state_reg == S_SCAN))
        else $error("allocate did not start a scan");

    a_load_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.func == FUNC_LOAD)) |=> (state_reg == S_IDLE))
        else $error("load left the idle state");
`endif
endmodule

@@ bench/fit_policy_hole_allocator_unit_test.sv @@
// Self-checking testbench for the fit policy hole allocator: directed and random requests against a predictor.
module fit_policy_hole_allocator_unit_test;
    import fpha_pkg::*;

    localparam logic [POLICY_BITS-1:0] POLICY_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 400;
    localparam int PHASES        = 20;
    localparam int PHASE_ITEMS   = 48;

    typedef struct packed {
        logic [FUNC_BITS-1:0]   func;
        logic [SLOT_BITS-1:0]   slot;
        logic [AMOUNT_BITS-1:0] amount;
    } hole_req_t;

    typedef struct packed {
        logic                  granted;
        logic [BLOCK_BITS-1:0] block;
        logic [LEFT_BITS-1:0]  left_over;
    } grant_t;

    logic clk = 1'b0;
    logic rst_n;

    fpha_cfg_if cfg_bus ();
    fpha_req_if req_bus ();
    fpha_rsp_if rsp_bus ();

    fit_policy_hole_allocator_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    hole_req_t req_backlog [$];
    grant_t    grant_expect [$];

    logic [AMOUNT_BITS-1:0] hole_shadow [DEF_HOLES];
    logic [POLICY_BITS-1:0] shadow_policy;
    logic [COUNT_BITS-1:0]  shadow_count;

    int  mismatches;
    int  send_gap;
    int  take_gap;
    int  hold_left;
    bit  hold_done;
    bit  long_hold_req;
    bit  no_idle;

    always #4 clk = ~clk;

    task automatic log_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic grant_t place_request(input logic [AMOUNT_BITS-1:0] want);
        int     n;
        int     pick;
        int     i;
        grant_t r;
        n    = (shadow_count > DEF_HOLES) ? DEF_HOLES : int'(shadow_count);
        pick = -1;
        if (shadow_policy == POLICY_FIRST)
        begin
            for (i = 0; i < n; i++)
                if (pick < 0 && hole_shadow[i] >= want)
                    pick = i;
        end
        else if (shadow_policy == POLICY_BEST)
        begin
            for (i = 0; i < n; i++)
                if (hole_shadow[i] >= want && (pick < 0 || hole_shadow[i] <= hole_shadow[pick]))
                    pick = i;
        end
        else if (n > 0)
        begin
            pick = 0;
            for (i = 1; i < n; i++)
                if (hole_shadow[i] > hole_shadow[pick])
                    pick = i;
            if (hole_shadow[pick] < want)
                pick = -1;
        end
        r = '0;
        if (pick >= 0)
        begin
            hole_shadow[pick] = hole_shadow[pick] - want;
            r.granted   = 1'b1;
            r.block     = BLOCK_BITS'(pick);
            r.left_over = hole_shadow[pick];
        end
        return r;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid  <= 1'b0;
            req_bus.func   <= FUNC_LOAD;
            req_bus.slot   <= '0;
            req_bus.amount <= '0;
            send_gap       <= 0;
        end
        else
        begin : feed
            hole_req_t nxt;
            if (req_bus.valid && req_bus.ready)
            begin
                if (req_bus.func == FUNC_ALLOC)
                    grant_expect.push_back(place_request(req_bus.amount));
                else
                    hole_shadow[req_bus.slot] = req_bus.amount;
            end
            if (!req_bus.valid || req_bus.ready)
            begin
                if (send_gap != 0)
                begin
                    req_bus.valid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end
                else if (!no_idle && $urandom_range(0, 5) == 0)
                begin
                    req_bus.valid <= 1'b0;
                    send_gap      <= $urandom_range(0, 4);
                end
                else if (req_backlog.size() != 0)
                begin
                    nxt = req_backlog.pop_front();
                    req_bus.valid  <= 1'b1;
                    req_bus.func   <= nxt.func;
                    req_bus.slot   <= nxt.slot;
                    req_bus.amount <= nxt.amount;
                end
                else
                    req_bus.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            take_gap      <= 0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else
        begin : watch
            grant_t want;
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (grant_expect.size() == 0)
                    log_mismatch("unexpected transfer, block", rsp_bus.block, 0);
                else
                begin
                    want = grant_expect.pop_front();
                    if (rsp_bus.granted !== want.granted)
                        log_mismatch("granted", rsp_bus.granted, want.granted);
                    if (rsp_bus.block !== want.block)
                        log_mismatch("block", rsp_bus.block, want.block);
                    if (rsp_bus.left_over !== want.left_over)
                        log_mismatch("left_over", rsp_bus.left_over, want.left_over);
                end
            end
            if (long_hold_req && !hold_done)
            begin
                hold_done     <= 1'b1;
                hold_left     <= LONG_HOLD;
                rsp_bus.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left     <= hold_left - 1;
                rsp_bus.ready <= 1'b0;
            end
            else if (take_gap != 0)
            begin
                take_gap      <= take_gap - 1;
                rsp_bus.ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                take_gap      <= $urandom_range(0, 4);
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    task automatic wait_idle();
        do
        begin
            while (req_backlog.size() != 0 || req_bus.valid || grant_expect.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
        while (req_backlog.size() != 0 || req_bus.valid || grant_expect.size() != 0);
    endtask

    task automatic write_config(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CFG_DAT_BITS-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
        if (idx == CFG_POLICY)
            shadow_policy = val[POLICY_BITS-1:0];
        else
            shadow_count = val;
        @(posedge clk);
    endtask

    task automatic push_item(input logic [FUNC_BITS-1:0] f, input int s, input int a);
        req_backlog.push_back(hole_req_t'{f, SLOT_BITS'(s), AMOUNT_BITS'(a)});
    endtask

    task automatic queue_directed();
        int seed_sizes [DEF_HOLES] = '{0, 100, 300, 100, 65535, 7, 300, 1,
                                       2, 3, 4, 5, 6, 8, 9, 65535};
        int i;
        // no holes in use right after reset
        push_item(FUNC_ALLOC, 0, 0);
        for (i = 0; i < DEF_HOLES; i++)
            push_item(FUNC_LOAD, i, seed_sizes[i]);
        wait_idle();
        write_config(CFG_POLICY, CFG_DAT_BITS'(POLICY_FIRST));
        write_config(CFG_COUNT, CFG_DAT_BITS'(DEF_HOLES));
        push_item(FUNC_ALLOC, 15, 100);
        push_item(FUNC_ALLOC, 0, 0);
        wait_idle();
        write_config(CFG_POLICY, CFG_DAT_BITS'(POLICY_BEST));
        push_item(FUNC_ALLOC, 0, 100);
        push_item(FUNC_ALLOC, 0, 300);
        wait_idle();
        write_config(CFG_POLICY, CFG_DAT_BITS'(POLICY_WORST));
        push_item(FUNC_ALLOC, 0, 65535);
        push_item(FUNC_ALLOC, 0, 65535);
        push_item(FUNC_ALLOC, 0, 65535);
        wait_idle();
        write_config(CFG_POLICY, CFG_DAT_BITS'(POLICY_SPARE));
        push_item(FUNC_ALLOC, 0, 1);
        wait_idle();
        write_config(CFG_POLICY, CFG_DAT_BITS'(POLICY_FIRST));
        write_config(CFG_COUNT, 5'd31);
        push_item(FUNC_ALLOC, 0, 65535);
    endtask

    function automatic logic [CFG_DAT_BITS-1:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return CFG_DAT_BITS'(DEF_HOLES);
        else if (r == 2)
            return CFG_DAT_BITS'($urandom_range(DEF_HOLES + 1, 31));
        return CFG_DAT_BITS'($urandom_range(1, DEF_HOLES));
    endfunction

    task automatic queue_random_phase(input int items, input bit alloc_heavy);
        int tops [4] = '{15, 255, 4095, 65535};
        int top;
        int k;
        int r;
        top = tops[$urandom_range(0, 3)];
        for (k = 0; k < items; k++)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < (alloc_heavy ? 85 : 55))
            begin
                if (r < 8)
                    push_item(FUNC_ALLOC, $urandom_range(0, 15), 0);
                else if (r < 14)
                    push_item(FUNC_ALLOC, $urandom_range(0, 15), $urandom_range(0, 65535));
                else
                    push_item(FUNC_ALLOC, $urandom_range(0, 15), $urandom_range(0, top / 3));
            end
            else if (r < 6)
                push_item(FUNC_LOAD, $urandom_range(0, 15), 65535);
            else if (r < 10)
                push_item(FUNC_LOAD, $urandom_range(0, 15), 0);
            else
                push_item(FUNC_LOAD, $urandom_range(0, 15), $urandom_range(0, top));
        end
    endtask

    initial
    begin : stimulus
        int ph;
        rst_n          = 1'b0;
        cfg_bus.valid  = 1'b0;
        cfg_bus.index  = CFG_POLICY;
        cfg_bus.data   = '0;
        req_bus.valid  = 1'b0;
        req_bus.func   = FUNC_LOAD;
        req_bus.slot   = '0;
        req_bus.amount = '0;
        rsp_bus.ready  = 1'b0;
        long_hold_req  = 1'b0;
        no_idle        = 1'b0;
        mismatches     = 0;
        shadow_policy  = POLICY_FIRST;
        shadow_count   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        queue_directed();
        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            write_config(CFG_POLICY,
                         CFG_DAT_BITS'({3'($urandom_range(0, 7)),
                                        POLICY_BITS'($urandom_range(0, 3))}));
            write_config(CFG_COUNT, (ph == 2) ? CFG_DAT_BITS'(DEF_HOLES) : pick_count());
            if (ph == 2)
                long_hold_req <= 1'b1;
            if (ph == PHASES - 3)
                no_idle <= 1'b1;
            queue_random_phase(PHASE_ITEMS, ph == 2);
        end
        wait_idle();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
src/fpha_pkg.sv
src/fpha_req_if.sv
src/fpha_rsp_if.sv
src/fpha_cfg_if.sv
src/fpha_ram.sv
src/fpha_pick.sv
src/fit_policy_hole_allocator_unit.sv
bench/fit_policy_hole_allocator_unit_test.sv
